/* hw/rtl/escape_sequence_decoder_defines.svh */
// assertion macros shared by the escape sequence decoder rtl
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define ESD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication whose consequent is checked in the cycle after the trigger
`define ESD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/esd_pkg.sv */
// types, codes and helpers for the escape sequence decoder
package esd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // decode mode codes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_OCT1  = 2'd2;
  localparam logic [1:0] MODE_OCT2  = 2'd3;

  // characters of interest
  localparam logic [BYTE_W-1:0] CHR_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CHR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_SEVEN  = 8'h37;

  // one decoded character and its end-of-string flag
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

  function automatic logic is_oct(input logic [BYTE_W-1:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_SEVEN);
  endfunction

  // letter after a backslash to control code, anything else stands for itself
  function automatic logic [BYTE_W-1:0] map_escape(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    unique case (b)
      8'h61:   r = 8'h07;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h76:   r = 8'h0B;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/escape_sequence_decoder.sv */
// backslash escape decoder (control letters and octal values) with a small result queue
//
// Input channel (in_valid, in_stall, in_byte, in_last): one raw character per
// transaction, in_last on the final character of a string. Output channel
// (out_valid, out_stall, out_byte, out_last): decoded characters, out_last on
// the final decoded character of a string.
// Each accepted character is decoded in the cycle it is taken, against the
// decode mode and octal accumulator registers, and its zero, one or two
// results are written into a four-entry result queue. With the queue empty a
// result is offered in the cycle after its character is accepted, else behind
// the results still queued.
// Throughput is one character per cycle while in_stall is low. A character that
// closes a pending octal value with another ordinary character yields two
// results, and the output port drains one result per cycle while out_stall is
// low; the queue absorbs the extra result.
// When the receiver stalls, the queue fills and in_stall rises once fewer than
// two free entries remain; nothing is lost.
// Synchronous reset empties the queue and returns to plain text mode.
module escape_sequence_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [esd_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [esd_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);
  import esd_pkg::*;

  `include "escape_sequence_decoder_defines.svh"

  logic [1:0]        mode_r, mode_nxt;
  logic [BYTE_W-1:0] acc_r, acc_nxt;
  res_t              fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              in_acc, out_acc;
  logic [1:0]        push_n;
  res_t              res0, res1;
  logic              plain_emit;
  logic [1:0]        plain_mode;
  logic [BYTE_W-1:0] digit, oct_sum;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // plain text handling of the incoming character
  always_comb begin
    if (in_byte == CHR_BSLASH && !in_last) begin
      plain_emit = 1'b0;
      plain_mode = MODE_ESC;
    end else begin
      plain_emit = 1'b1;
      plain_mode = MODE_PLAIN;
    end
  end

  assign digit   = in_byte - CHR_ZERO;
  assign oct_sum = {acc_r[BYTE_W-4:0], 3'b000} + digit;

  // decode one character against the current mode
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    push_n   = 2'd0;
    res0     = '{data: in_byte, last: in_last};
    res1     = '{data: in_byte, last: in_last};
    unique case (mode_r) inside
      MODE_PLAIN: begin
        push_n   = {1'b0, plain_emit};
        mode_nxt = plain_mode;
      end
      MODE_ESC: begin
        if (is_oct(in_byte)) begin
          acc_nxt = digit;
          if (in_last) begin
            push_n   = 2'd1;
            res0     = '{data: digit, last: 1'b1};
            mode_nxt = MODE_PLAIN;
          end else begin
            mode_nxt = MODE_OCT1;
          end
        end else begin
          push_n   = 2'd1;
          res0     = '{data: map_escape(in_byte), last: in_last};
          mode_nxt = MODE_PLAIN;
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        if (is_oct(in_byte)) begin
          acc_nxt = oct_sum;
          if (mode_r == MODE_OCT1 && !in_last) begin
            mode_nxt = MODE_OCT2;
          end else begin
            push_n   = 2'd1;
            res0     = '{data: oct_sum, last: in_last};
            mode_nxt = MODE_PLAIN;
          end
        end else begin
          // flush the pending octal value, then treat the character as plain
          res0     = '{data: acc_r, last: 1'b0};
          push_n   = plain_emit ? 2'd2 : 2'd1;
          mode_nxt = plain_mode;
        end
      end
      default: mode_nxt = MODE_PLAIN;
    endcase
  end

  // decode state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r  <= '0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_acc && push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (in_acc && push_n == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  // queue occupancy
  always_comb begin
    count_nxt = count_r + (in_acc ? CNT_W'(push_n) : CNT_W'(0))
                        - (out_acc ? CNT_W'(1) : CNT_W'(0));
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // output side and back pressure
  assign out_valid = (count_r != '0);
  assign out_byte  = fifo_r[rd_ptr_r].data;
  assign out_last  = fifo_r[rd_ptr_r].last;
  assign in_stall  = (count_r > CNT_W'(FIFO_DEPTH - 2));

  // checks
  `ESD_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `ESD_ASSERT_NEXT(a_last_plain, in_acc && in_last, mode_r == MODE_PLAIN, "mode not plain after string end")
  `ESD_ASSERT_NEXT(a_push_valid, in_acc && push_n != 2'd0, out_valid, "pushed result not offered")
  `ESD_ASSERT_NEXT(a_idle_empty, !out_valid && !in_acc, !out_valid, "result appeared with no input")

endmodule
